FILE: rtl/sahsf_pkg.sv
// shared types, command codes and constants of the binned sah split finder
package sahsf_pkg;

   localparam int DEF_MAX_PRIMS  = 4096;
   localparam int DEF_MAX_BINS   = 128;
   localparam int DEF_COORD_BITS = 24;

   localparam int NB_W    = 9;             // bins count, up to 256
   localparam int MUL_W   = 27;            // multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int COST_W  = 63;
   localparam logic [COST_W-1:0] COST_CAP = {COST_W{1'b1}};
   localparam logic [7:0] BINS_RESET = 8'd128;

   localparam logic [3:0] MUL_OFF_NB = 4'd0;
   localparam logic [3:0] MUL_EXY    = 4'd1;
   localparam logic [3:0] MUL_EYZ    = 4'd2;
   localparam logic [3:0] MUL_EZX    = 4'd3;
   localparam logic [3:0] MUL_LC_LO  = 4'd4;
   localparam logic [3:0] MUL_LC_HI  = 4'd5;
   localparam logic [3:0] MUL_RC_LO  = 4'd6;
   localparam logic [3:0] MUL_RC_HI  = 4'd7;
   localparam logic [3:0] MUL_POS    = 4'd8;

   typedef struct packed {
      logic       accept;
      logic       store_rd;
      logic       bin_clr;
      logic       bin_rd;
      logic       bin_rd_q;
      logic       bin_upd;
      logic       suf_rd;
      logic       suf_wr;
      logic       run_clr;
      logic       run_grow;
      logic       lc_clr;
      logic       lc_add;
      logic       acc_load;
      logic       acc_add;
      logic       t_load;
      logic       left_fin;
      logic       right_fin;
      logic       best_clr;
      logic       best_upd;
      logic       div_start;
      logic       div_pos;
      logic       pos_fin;
      logic       out_load;
      logic [3:0] mul_op;
   } sahsf_cmd_type;

   typedef struct packed {
      logic range_pos;
      logic div_done;
      logic rsp_free;
      logic found;
   } sahsf_sts_type;

endpackage

FILE: rtl/sah_binned_split_finder.sv
// top level: binned surface-area split finder for one bvh node
// load: one primitive word per cycle while in the load state; the word marked last
// starts evaluation. evaluation per axis with nonzero centroid range: the bins are
// cleared, then each primitive is binned through the bit-serial divider, then the
// suffix sweep and the prefix sweep run over the bins. the split position follows;
// loading resumes once the result is taken into the result register.
// synchronous reset empties the node and sets bins_in_use to 128.
module sah_binned_split_finder import sahsf_pkg::*; #(
   parameter int MAX_PRIMS  = DEF_MAX_PRIMS,
   parameter int MAX_BINS   = DEF_MAX_BINS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
   // center_x, center_y, center_z
   input  logic [((9*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // chosen axis, bin, split position, cost numerator, overflow
   output logic [((73+COORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   // found
   output logic                                   rsp_tuser,
   input  logic                                   csr_wr_en,
   input  logic [7:0]                             csr_wr_data
);

   localparam int C     = COORD_BITS;
   localparam int RSP_W = ((73 + C + 7) / 8) * 8;

   sahsf_cmd_type                     cmd;
   sahsf_sts_type                     sts;
   logic [1:0]                        axis;
   logic [$clog2(MAX_PRIMS)-1:0]      prim_idx;
   logic [$clog2(MAX_BINS)-1:0]       bin_idx;
   logic [$clog2(MAX_PRIMS+1)-1:0]    prim_count;
   logic [NB_W-1:0]                   nbins;
   logic                              rsp_found;
   logic [1:0]                        rsp_axis;
   logic [6:0]                        rsp_bin;
   logic [C-1:0]                      rsp_pos;
   logic [COST_W-1:0]                 rsp_cost;
   logic                              rsp_overflow;

   sahsf_ctrl #(
      .MAX_PRIMS (MAX_PRIMS),
      .MAX_BINS  (MAX_BINS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_last   (req_tlast),
      .req_ready  (req_tready),
      .sts        (sts),
      .prim_count (prim_count),
      .nbins      (nbins),
      .cmd        (cmd),
      .axis       (axis),
      .prim_idx   (prim_idx),
      .bin_idx    (bin_idx)
   );

   sahsf_dpath #(
      .MAX_PRIMS  (MAX_PRIMS),
      .MAX_BINS   (MAX_BINS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .axis         (axis),
      .prim_idx     (prim_idx),
      .bin_idx      (bin_idx),
      .req_data     (req_tdata[9*C-1:0]),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_ready    (rsp_tready),
      .sts          (sts),
      .prim_count   (prim_count),
      .nbins        (nbins),
      .rsp_valid    (rsp_tvalid),
      .rsp_found    (rsp_found),
      .rsp_axis     (rsp_axis),
      .rsp_bin      (rsp_bin),
      .rsp_pos      (rsp_pos),
      .rsp_cost     (rsp_cost),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata = RSP_W'({rsp_overflow, rsp_cost, rsp_pos, rsp_bin, rsp_axis});
   assign rsp_tuser = rsp_found;

endmodule

FILE: rtl/sahsf_div.sv
// iterative restoring divider, one quotient bit per cycle
module sahsf_div import sahsf_pkg::*; #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= diff[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

FILE: rtl/sahsf_dpath.sv
// datapath: primitive store, bin memories, multiplier, divider, cost and result registers
module sahsf_dpath import sahsf_pkg::*; #(
   parameter int MAX_PRIMS  = DEF_MAX_PRIMS,
   parameter int MAX_BINS   = DEF_MAX_BINS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sahsf_cmd_type                     cmd,
   input  logic [1:0]                        axis,
   input  logic [$clog2(MAX_PRIMS)-1:0]      prim_idx,
   input  logic [$clog2(MAX_BINS)-1:0]       bin_idx,
   input  logic [9*COORD_BITS-1:0]           req_data,
   input  logic                              csr_wr_en,
   input  logic [7:0]                        csr_wr_data,
   input  logic                              rsp_ready,
   output sahsf_sts_type                     sts,
   output logic [$clog2(MAX_PRIMS+1)-1:0]    prim_count,
   output logic [NB_W-1:0]                   nbins,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [1:0]                        rsp_axis,
   output logic [6:0]                        rsp_bin,
   output logic [COORD_BITS-1:0]             rsp_pos,
   output logic [COST_W-1:0]                 rsp_cost,
   output logic                              rsp_overflow
);

   localparam int C      = COORD_BITS;
   localparam int ADDR_W = $clog2(MAX_PRIMS);
   localparam int CNT_W  = $clog2(MAX_PRIMS + 1);
   localparam int BIN_W  = $clog2(MAX_BINS);
   localparam int EXT_W  = C + 1;
   localparam int AREA_W = 2 * EXT_W + 3;
   localparam int ACC_W  = AREA_W - 1;
   localparam int NUM_W  = C + NB_W;
   localparam int SUM_W  = PROD_W + MUL_W + 1;
   localparam int ST_W   = 9 * C;
   localparam int BW     = CNT_W + 6 * C + 1;

   // node state
   logic [CNT_W-1:0]    prim_count_ff;
   logic                dropped_ff;
   logic                bnd_valid_ff;
   logic signed [C-1:0] bnd_lo_ff [3];
   logic signed [C-1:0] bnd_hi_ff [3];
   logic [7:0]          bins_ff;

   logic [ST_W-1:0] store_mem [MAX_PRIMS];
   logic [ST_W-1:0] store_rd_ff;
   logic [BW-1:0]   bin_mem [MAX_BINS];
   logic [BW-1:0]   bin_rd_ff;
   logic [AREA_W-1:0] suf_mem [MAX_BINS];
   logic [AREA_W-1:0] suf_rd_ff;

   logic                run_valid_ff;
   logic signed [C-1:0] run_lo_ff [3];
   logic signed [C-1:0] run_hi_ff [3];
   logic [CNT_W-1:0]    lc_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   t_ff;
   logic [COST_W-1:0]   left_ff;
   logic [COST_W-1:0]   right_ff;

   logic                found_ff;
   logic [COST_W-1:0]   best_cost_ff;
   logic [1:0]          best_axis_ff;
   logic [BIN_W-1:0]    best_bin_ff;
   logic signed [C-1:0] pos_ff;

   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [1:0]          rsp_axis_ff;
   logic [6:0]          rsp_bin_ff;
   logic [C-1:0]        rsp_pos_ff;
   logic [COST_W-1:0]   rsp_cost_ff;
   logic                rsp_overflow_ff;

   logic                store_wr;
   logic signed [C-1:0] in_cen [3];
   logic signed [C-1:0] st_min [3];
   logic signed [C-1:0] st_max [3];
   logic signed [C-1:0] st_cen [3];
   logic signed [C-1:0] bn_lo [3];
   logic signed [C-1:0] bn_hi [3];
   logic [EXT_W-1:0]    ext [3];
   logic [1:0]          ax_i;
   logic signed [EXT_W-1:0] rng_d;
   logic signed [EXT_W-1:0] best_rng_d;
   logic signed [EXT_W-1:0] off_d;
   logic [NB_W-1:0]     nb_m1;
   logic [NUM_W-1:0]    div_quo;
   logic                div_done;
   logic [EXT_W-1:0]    div_den;
   logic [NB_W-1:0]     q_clamp;
   logic [BIN_W-1:0]    q_addr;
   logic [BIN_W-1:0]    bin_rd_addr;
   logic [BIN_W-1:0]    bin_wr_addr;
   logic [BW-1:0]       bin_wdata;
   logic [CNT_W-1:0]    rc;
   logic [AREA_W-1:0]   area_v;
   logic [PROD_W-1:0]   area_ext;
   logic [PROD_W-1:0]   suf_ext;
   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [SUM_W-1:0]    term_sum;
   logic [COST_W-1:0]   term_sat;
   logic [COST_W:0]     cost_sum;
   logic [COST_W-1:0]   cost;
   logic [BIN_W+6:0]    bin_wide;

   // clamp of the bins register
   always_comb begin
      if (bins_ff < 8'd2) begin
         nbins = NB_W'(2);
      end else if (NB_W'(bins_ff) > NB_W'(MAX_BINS)) begin
         nbins = NB_W'(MAX_BINS);
      end else begin
         nbins = NB_W'(bins_ff);
      end
   end
   assign nb_m1 = nbins - 1'b1;

   assign store_wr = cmd.accept && (prim_count_ff < CNT_W'(MAX_PRIMS));
   assign ax_i     = (axis == 2'd3) ? 2'd2 : axis;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_cen[k] = req_data[C*(6+k) +: C];
         st_min[k] = store_rd_ff[C*k +: C];
         st_max[k] = store_rd_ff[C*(3+k) +: C];
         st_cen[k] = store_rd_ff[C*(6+k) +: C];
         bn_lo[k]  = bin_rd_ff[CNT_W + C*k +: C];
         bn_hi[k]  = bin_rd_ff[CNT_W + C*(3+k) +: C];
      end
   end

   // extents of the running box, an inverted one counts as zero
   always_comb begin
      logic signed [EXT_W-1:0] d;
      for (int k = 0; k < 3; k++) begin
         d = EXT_W'(run_hi_ff[k]) - EXT_W'(run_lo_ff[k]);
         ext[k] = d[EXT_W-1] ? '0 : d;
      end
   end

   assign rng_d      = EXT_W'(bnd_hi_ff[ax_i]) - EXT_W'(bnd_lo_ff[ax_i]);
   assign best_rng_d = EXT_W'(bnd_hi_ff[best_axis_ff]) - EXT_W'(bnd_lo_ff[best_axis_ff]);
   assign off_d      = EXT_W'(st_cen[ax_i]) - EXT_W'(bnd_lo_ff[ax_i]);

   // node load, centroid bounds and the bins register
   always_ff @(posedge clock) begin
      if (reset) begin
         prim_count_ff <= '0;
         dropped_ff    <= 1'b0;
         bnd_valid_ff  <= 1'b0;
         bins_ff       <= BINS_RESET;
      end else begin
         if (csr_wr_en) begin
            bins_ff <= csr_wr_data;
         end
         if (cmd.out_load) begin
            prim_count_ff <= '0;
            dropped_ff    <= 1'b0;
            bnd_valid_ff  <= 1'b0;
         end else if (cmd.accept) begin
            if (store_wr) begin
               prim_count_ff <= prim_count_ff + 1'b1;
               bnd_valid_ff  <= 1'b1;
            end else begin
               dropped_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         for (int k = 0; k < 3; k++) begin
            if (!bnd_valid_ff || in_cen[k] < bnd_lo_ff[k]) begin
               bnd_lo_ff[k] <= in_cen[k];
            end
            if (!bnd_valid_ff || in_cen[k] > bnd_hi_ff[k]) begin
               bnd_hi_ff[k] <= in_cen[k];
            end
         end
      end
   end

   // primitive store
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[prim_count_ff[ADDR_W-1:0]] <= req_data;
      end
      if (cmd.store_rd) begin
         store_rd_ff <= store_mem[prim_idx];
      end
   end

   // bin index of the current centroid, clamped to the last bin
   assign q_clamp = (div_quo > NUM_W'(nb_m1)) ? nb_m1 : div_quo[NB_W-1:0];
   assign q_addr  = q_clamp[BIN_W-1:0];
   assign bin_rd_addr = cmd.bin_rd_q ? q_addr : bin_idx;
   assign bin_wr_addr = cmd.bin_clr ? bin_idx : q_addr;

   always_comb begin
      bin_wdata = '0;
      if (!cmd.bin_clr) begin
         bin_wdata[CNT_W-1:0] = bin_rd_ff[CNT_W-1:0] + 1'b1;
         bin_wdata[BW-1]      = 1'b1;
         for (int k = 0; k < 3; k++) begin
            bin_wdata[CNT_W + C*k +: C] =
               (!bin_rd_ff[BW-1] || st_min[k] < bn_lo[k]) ? st_min[k] : bn_lo[k];
            bin_wdata[CNT_W + C*(3+k) +: C] =
               (!bin_rd_ff[BW-1] || st_max[k] > bn_hi[k]) ? st_max[k] : bn_hi[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bin_clr || cmd.bin_upd) begin
         bin_mem[bin_wr_addr] <= bin_wdata;
      end
      if (cmd.bin_rd || cmd.bin_rd_q) begin
         bin_rd_ff <= bin_mem[bin_rd_addr];
      end
   end

   // suffix areas, written one bin below the one just grown
   always_ff @(posedge clock) begin
      if (cmd.suf_wr) begin
         suf_mem[bin_idx - 1'b1] <= area_v;
      end
      if (cmd.suf_rd) begin
         suf_rd_ff <= suf_mem[bin_idx];
      end
   end

   // running box and left count
   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
      end else if (cmd.run_clr) begin
         run_valid_ff <= 1'b0;
      end else if (cmd.run_grow && bin_rd_ff[BW-1]) begin
         run_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.run_grow && bin_rd_ff[BW-1]) begin
         for (int k = 0; k < 3; k++) begin
            if (!run_valid_ff || bn_lo[k] < run_lo_ff[k]) begin
               run_lo_ff[k] <= bn_lo[k];
            end
            if (!run_valid_ff || bn_hi[k] > run_hi_ff[k]) begin
               run_hi_ff[k] <= bn_hi[k];
            end
         end
      end
      if (cmd.lc_clr) begin
         lc_ff <= '0;
      end else if (cmd.lc_add) begin
         lc_ff <= lc_ff + bin_rd_ff[CNT_W-1:0];
      end
   end

   assign rc       = prim_count_ff - lc_ff;
   assign area_v   = run_valid_ff ? {acc_ff, 1'b0} : '0;
   assign area_ext = PROD_W'(area_v);
   assign suf_ext  = PROD_W'(suf_rd_ff);

   // shared multiplier
   always_comb begin
      case (cmd.mul_op)
         MUL_OFF_NB: begin
            mul_a = MUL_W'(off_d);
            mul_b = MUL_W'(nbins);
         end
         MUL_EXY: begin
            mul_a = MUL_W'(ext[0]);
            mul_b = MUL_W'(ext[1]);
         end
         MUL_EYZ: begin
            mul_a = MUL_W'(ext[1]);
            mul_b = MUL_W'(ext[2]);
         end
         MUL_EZX: begin
            mul_a = MUL_W'(ext[2]);
            mul_b = MUL_W'(ext[0]);
         end
         MUL_LC_LO: begin
            mul_a = MUL_W'(lc_ff);
            mul_b = area_ext[MUL_W-1:0];
         end
         MUL_LC_HI: begin
            mul_a = MUL_W'(lc_ff);
            mul_b = area_ext[PROD_W-1:MUL_W];
         end
         MUL_RC_LO: begin
            mul_a = MUL_W'(rc);
            mul_b = suf_ext[MUL_W-1:0];
         end
         MUL_RC_HI: begin
            mul_a = MUL_W'(rc);
            mul_b = suf_ext[PROD_W-1:MUL_W];
         end
         MUL_POS: begin
            mul_a = MUL_W'(NB_W'(best_bin_ff) + 1'b1);
            mul_b = MUL_W'(best_rng_d);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // high half of a product joins the low half, saturated to the cost cap
   assign term_sum = SUM_W'(t_ff) + (SUM_W'(prod_ff) << MUL_W);
   assign term_sat = (term_sum > SUM_W'(COST_CAP)) ? COST_CAP : term_sum[COST_W-1:0];
   assign cost_sum = {1'b0, left_ff} + {1'b0, right_ff};
   assign cost     = cost_sum[COST_W] ? COST_CAP : cost_sum[COST_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.acc_load) begin
         acc_ff <= prod_ff[ACC_W-1:0];
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
      end
      if (cmd.t_load) begin
         t_ff <= prod_ff;
      end
      if (cmd.left_fin) begin
         left_ff <= term_sat;
      end
      if (cmd.right_fin) begin
         right_ff <= term_sat;
      end
   end

   assign div_den = cmd.div_pos ? EXT_W'(nbins) : rng_d;

   sahsf_div #(
      .NUM_W (NUM_W),
      .DEN_W (EXT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (prod_ff[NUM_W-1:0]),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   // best candidate so far
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.best_clr) begin
         found_ff <= 1'b0;
      end else if (cmd.best_upd && (!found_ff || cost < best_cost_ff)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.best_upd && (!found_ff || cost < best_cost_ff)) begin
         best_cost_ff <= cost;
         best_axis_ff <= ax_i;
         best_bin_ff  <= bin_idx;
      end
      if (cmd.pos_fin) begin
         pos_ff <= bnd_lo_ff[best_axis_ff] + div_quo[C-1:0];
      end
   end

   assign bin_wide = (BIN_W + 7)'(best_bin_ff);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found_ff    <= found_ff;
         rsp_axis_ff     <= found_ff ? best_axis_ff : 2'd0;
         rsp_bin_ff      <= found_ff ? bin_wide[6:0] : 7'd0;
         rsp_pos_ff      <= found_ff ? pos_ff : '0;
         rsp_cost_ff     <= found_ff ? best_cost_ff : '0;
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign sts.range_pos = bnd_valid_ff && !rng_d[EXT_W-1] && (rng_d != '0);
   assign sts.div_done  = div_done;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign sts.found     = found_ff;

   assign prim_count   = prim_count_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_axis     = rsp_axis_ff;
   assign rsp_bin      = rsp_bin_ff;
   assign rsp_pos      = rsp_pos_ff;
   assign rsp_cost     = rsp_cost_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

FILE: rtl/sahsf_ctrl.sv
// controller: sequences load, binning, suffix and prefix sweeps, split position and result
module sahsf_ctrl import sahsf_pkg::*; #(
   parameter int MAX_PRIMS = DEF_MAX_PRIMS,
   parameter int MAX_BINS  = DEF_MAX_BINS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_last,
   output logic                           req_ready,
   input  sahsf_sts_type                  sts,
   input  logic [$clog2(MAX_PRIMS+1)-1:0] prim_count,
   input  logic [NB_W-1:0]                nbins,
   output sahsf_cmd_type                  cmd,
   output logic [1:0]                     axis,
   output logic [$clog2(MAX_PRIMS)-1:0]   prim_idx,
   output logic [$clog2(MAX_BINS)-1:0]    bin_idx
);

   localparam int ADDR_W = $clog2(MAX_PRIMS);
   localparam int CNT_W  = $clog2(MAX_PRIMS + 1);
   localparam int BIN_W  = $clog2(MAX_BINS);

   localparam logic [4:0] ST_LOAD     = 5'd0;
   localparam logic [4:0] ST_START    = 5'd1;
   localparam logic [4:0] ST_AXIS     = 5'd2;
   localparam logic [4:0] ST_CLR      = 5'd3;
   localparam logic [4:0] ST_B_RD     = 5'd4;
   localparam logic [4:0] ST_B_MUL    = 5'd5;
   localparam logic [4:0] ST_B_DIV    = 5'd6;
   localparam logic [4:0] ST_B_WAIT   = 5'd7;
   localparam logic [4:0] ST_B_UPD    = 5'd8;
   localparam logic [4:0] ST_S_INIT   = 5'd9;
   localparam logic [4:0] ST_S_RD     = 5'd10;
   localparam logic [4:0] ST_S_GROW   = 5'd11;
   localparam logic [4:0] ST_A1       = 5'd12;
   localparam logic [4:0] ST_A2       = 5'd13;
   localparam logic [4:0] ST_A3       = 5'd14;
   localparam logic [4:0] ST_A4       = 5'd15;
   localparam logic [4:0] ST_S_WR     = 5'd16;
   localparam logic [4:0] ST_P_INIT   = 5'd17;
   localparam logic [4:0] ST_P_RD     = 5'd18;
   localparam logic [4:0] ST_P_GROW   = 5'd19;
   localparam logic [4:0] ST_C1       = 5'd20;
   localparam logic [4:0] ST_C2       = 5'd21;
   localparam logic [4:0] ST_C3       = 5'd22;
   localparam logic [4:0] ST_C4       = 5'd23;
   localparam logic [4:0] ST_C5       = 5'd24;
   localparam logic [4:0] ST_C6       = 5'd25;
   localparam logic [4:0] ST_POS_CHK  = 5'd26;
   localparam logic [4:0] ST_POS_MUL  = 5'd27;
   localparam logic [4:0] ST_POS_DIV  = 5'd28;
   localparam logic [4:0] ST_POS_WAIT = 5'd29;
   localparam logic [4:0] ST_OUT      = 5'd30;

   logic [4:0]       state_ff, state_in;
   logic [1:0]       axis_ff, axis_in;
   logic [CNT_W-1:0] p_ff, p_in;
   logic [BIN_W-1:0] i_ff, i_in;
   logic             prefix_ff, prefix_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         axis_ff   <= 2'd0;
         p_ff      <= '0;
         i_ff      <= '0;
         prefix_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         axis_ff   <= axis_in;
         p_ff      <= p_in;
         i_ff      <= i_in;
         prefix_ff <= prefix_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      p_in      = p_ff;
      i_in      = i_ff;
      prefix_in = prefix_ff;
      cmd       = '0;
      cmd.accept = req_valid && req_ready;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.best_clr = 1'b1;
            axis_in      = 2'd0;
            state_in     = ST_AXIS;
         end
         ST_AXIS: begin
            if (axis_ff == 2'd3) begin
               state_in = ST_POS_CHK;
            end else if (sts.range_pos) begin
               i_in     = '0;
               p_in     = '0;
               state_in = ST_CLR;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_CLR: begin
            cmd.bin_clr = 1'b1;
            if (NB_W'(i_ff) == nbins - 1'b1) begin
               state_in = ST_B_RD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_B_RD: begin
            cmd.store_rd = 1'b1;
            state_in     = ST_B_MUL;
         end
         ST_B_MUL: begin
            cmd.mul_op = MUL_OFF_NB;
            state_in   = ST_B_DIV;
         end
         ST_B_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_B_WAIT;
         end
         ST_B_WAIT: begin
            if (sts.div_done) begin
               cmd.bin_rd_q = 1'b1;
               state_in     = ST_B_UPD;
            end
         end
         ST_B_UPD: begin
            cmd.bin_upd = 1'b1;
            if (p_ff + 1'b1 == prim_count) begin
               state_in = ST_S_INIT;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = ST_B_RD;
            end
         end
         ST_S_INIT: begin
            cmd.run_clr = 1'b1;
            i_in        = BIN_W'(nbins - 1'b1);
            prefix_in   = 1'b0;
            state_in    = ST_S_RD;
         end
         ST_S_RD: begin
            cmd.bin_rd = 1'b1;
            state_in   = ST_S_GROW;
         end
         ST_S_GROW: begin
            cmd.run_grow = 1'b1;
            state_in     = ST_A1;
         end
         // area of the running box, three products summed
         ST_A1: begin
            cmd.mul_op = MUL_EXY;
            state_in   = ST_A2;
         end
         ST_A2: begin
            cmd.mul_op   = MUL_EYZ;
            cmd.acc_load = 1'b1;
            state_in     = ST_A3;
         end
         ST_A3: begin
            cmd.mul_op  = MUL_EZX;
            cmd.acc_add = 1'b1;
            state_in    = ST_A4;
         end
         ST_A4: begin
            cmd.acc_add = 1'b1;
            state_in    = prefix_ff ? ST_C1 : ST_S_WR;
         end
         ST_S_WR: begin
            cmd.suf_wr = 1'b1;
            if (i_ff == BIN_W'(1)) begin
               state_in = ST_P_INIT;
            end else begin
               i_in     = i_ff - 1'b1;
               state_in = ST_S_RD;
            end
         end
         ST_P_INIT: begin
            cmd.run_clr = 1'b1;
            cmd.lc_clr  = 1'b1;
            i_in        = '0;
            prefix_in   = 1'b1;
            state_in    = ST_P_RD;
         end
         ST_P_RD: begin
            cmd.bin_rd = 1'b1;
            cmd.suf_rd = 1'b1;
            state_in   = ST_P_GROW;
         end
         ST_P_GROW: begin
            cmd.run_grow = 1'b1;
            cmd.lc_add   = 1'b1;
            state_in     = ST_A1;
         end
         ST_C1: begin
            cmd.mul_op = MUL_LC_LO;
            state_in   = ST_C2;
         end
         ST_C2: begin
            cmd.mul_op = MUL_LC_HI;
            cmd.t_load = 1'b1;
            state_in   = ST_C3;
         end
         ST_C3: begin
            cmd.mul_op   = MUL_RC_LO;
            cmd.left_fin = 1'b1;
            state_in     = ST_C4;
         end
         ST_C4: begin
            cmd.mul_op = MUL_RC_HI;
            cmd.t_load = 1'b1;
            state_in   = ST_C5;
         end
         ST_C5: begin
            cmd.right_fin = 1'b1;
            state_in      = ST_C6;
         end
         ST_C6: begin
            cmd.best_upd = 1'b1;
            if (NB_W'(i_ff) == nbins - NB_W'(2)) begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_AXIS;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_P_RD;
            end
         end
         ST_POS_CHK: begin
            state_in = sts.found ? ST_POS_MUL : ST_OUT;
         end
         ST_POS_MUL: begin
            cmd.mul_op = MUL_POS;
            state_in   = ST_POS_DIV;
         end
         ST_POS_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_pos   = 1'b1;
            state_in      = ST_POS_WAIT;
         end
         ST_POS_WAIT: begin
            cmd.div_pos = 1'b1;
            if (sts.div_done) begin
               cmd.pos_fin = 1'b1;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign axis     = axis_ff;
   assign prim_idx = p_ff[ADDR_W-1:0];
   assign bin_idx  = i_ff;

endmodule
